[design/shs_pkg.sv]
package shs_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] vars_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   typedef struct packed {
      word_type w0;
      word_type w1;
      word_type w9;
      word_type w14;
      word_type k;
   } sched_taps_type;

   typedef struct packed {
      vars_type vars;
      word_type new_w;
   } round_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMPRESS,
      ST_FINAL,
      ST_OUTPUT
   } state_type;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

   localparam word_type H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

[design/shs_stream_if.sv]
interface shs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/shs_round.sv]
module shs_round
   import shs_pkg::*;
(
   input  vars_type         vars,
   input  sched_taps_type   taps,
   output round_result_type result
);

   word_type big0;
   word_type big1;
   word_type choose;
   word_type major;
   word_type tmp1;
   word_type tmp2;
   word_type sg0;
   word_type sg1;

   always_comb begin
      big1   = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
      choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
      tmp1   = vars[7] + big1 + choose + taps.k + taps.w0;
      big0   = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
      major  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
      tmp2   = big0 + major;

      result.vars[7] = vars[6];
      result.vars[6] = vars[5];
      result.vars[5] = vars[4];
      result.vars[4] = vars[3] + tmp1;
      result.vars[3] = vars[2];
      result.vars[2] = vars[1];
      result.vars[1] = vars[0];
      result.vars[0] = tmp1 + tmp2;

      sg0 = rotr(taps.w1, 7) ^ rotr(taps.w1, 18) ^ (taps.w1 >> 3);
      sg1 = rotr(taps.w14, 17) ^ rotr(taps.w14, 19) ^ (taps.w14 >> 10);
      result.new_w = taps.w0 + sg0 + taps.w9 + sg1;
   end

endmodule

[design/sha256_stream_hasher_top.sv]
// SHA-256 stream hasher.
// req_if carries one message byte per transaction (data_byte, has_byte,
// end_of_message); rsp_if returns the eight digest words, word_index 0 first,
// last_word set on the eighth. An item with has_byte low and end_of_message
// high closes the message without adding a byte; one with both low is a no-op.
// Bytes are taken one per cycle while a block fills. The 64th byte of a block
// starts the compression: the rounds in the single shared round unit, then
// the chaining update, during all of which req_ready is low.
// After the end marker the block inserts padding one byte per cycle (9 to 72
// bytes, with one or two compressions), then presents the digest words one
// per cycle while rsp_ready is high. A stalled receiver holds the current word
// and the block accepts no new input until the eighth word is taken.
// Synchronous reset loads the initial hash values and clears the bit count
// and fill level; the same happens after the last digest word.
module sha256_stream_hasher_top
   import shs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   shs_stream_if.sink   req_if,
   shs_stream_if.source rsp_if
);

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [23:0] word_ff, word_in;
   word_type    win_ff [16];
   word_type    win_in [16];
   vars_type    vars_ff, vars_in;
   word_type    chain_ff [8];
   word_type    chain_in [8];
   logic [5:0]  round_ff, round_in;
   logic [63:0] bit_count_ff, bit_count_in;
   logic [63:0] len_ff, len_in;
   logic        first_ff, first_in;
   logic        lenph_ff, lenph_in;
   logic        pad_ff, pad_in;
   logic        fin_ff, fin_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic             push;
   logic [7:0]       push_byte;
   logic             len_now;
   logic [63:0]      len_shift;
   sched_taps_type   taps;
   round_result_type rnd;

   assign taps.w0  = win_ff[0];
   assign taps.w1  = win_ff[1];
   assign taps.w9  = win_ff[9];
   assign taps.w14 = win_ff[14];
   assign taps.k   = ROUND_K[round_ff];

   shs_round u_round (
      .vars   (vars_ff),
      .taps   (taps),
      .result (rnd)
   );

   assign rsp_if.payload.digest_word = chain_ff[out_idx_ff];
   assign rsp_if.payload.word_index  = out_idx_ff;
   assign rsp_if.payload.last_word   = (out_idx_ff == 3'd7);

   assign len_now   = !first_ff && ((fill_ff == LEN_POS) || lenph_ff);
   assign len_shift = len_ff << {fill_ff[2:0], 3'b000};

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      word_in      = word_ff;
      win_in       = win_ff;
      vars_in      = vars_ff;
      chain_in     = chain_ff;
      round_in     = round_ff;
      bit_count_in = bit_count_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      lenph_in     = lenph_ff;
      pad_in       = pad_ff;
      fin_in       = fin_ff;
      out_idx_in   = out_idx_ff;
      push         = 1'b0;
      push_byte    = req_if.payload.data_byte;
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               if (req_if.payload.has_byte) begin
                  push         = 1'b1;
                  bit_count_in = bit_count_ff + 64'd8;
               end
               if (req_if.payload.end_of_message) begin
                  pad_in   = 1'b1;
                  first_in = 1'b1;
                  lenph_in = 1'b0;
                  len_in   = bit_count_in;
               end
               if (push && (fill_ff == LAST_POS)) begin
                  state_in = ST_COMPRESS;
               end else if (req_if.payload.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push     = 1'b1;
            first_in = 1'b0;
            if (first_ff) begin
               push_byte = PAD_MARK;
            end else if (len_now) begin
               push_byte = len_shift[63:56];
            end else begin
               push_byte = 8'h00;
            end
            if (len_now) begin
               lenph_in = 1'b1;
            end
            if (fill_ff == LAST_POS) begin
               state_in = ST_COMPRESS;
               if (len_now) begin
                  fin_in = 1'b1;
                  pad_in = 1'b0;
               end
            end
         end
         ST_COMPRESS: begin
            vars_in = rnd.vars;
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = rnd.new_w;
            round_in   = round_ff + 6'd1;
            if (round_ff == LAST_POS) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
            priority if (fin_ff) begin
               state_in = ST_OUTPUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUTPUT: begin
            rsp_if.valid = 1'b1;
            if (rsp_if.ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  chain_in     = H0;
                  bit_count_in = '0;
                  fin_in       = 1'b0;
                  lenph_in     = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         word_in = {word_ff[15:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = {word_ff, push_byte};
         end
         if (fill_ff == LAST_POS) begin
            for (int i = 0; i < 8; i++) begin
               vars_in[i] = chain_ff[i];
            end
            round_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         chain_ff     <= H0;
         round_ff     <= '0;
         bit_count_ff <= '0;
         first_ff     <= 1'b0;
         lenph_ff     <= 1'b0;
         pad_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         chain_ff     <= chain_in;
         round_ff     <= round_in;
         bit_count_ff <= bit_count_in;
         first_ff     <= first_in;
         lenph_ff     <= lenph_in;
         pad_ff       <= pad_in;
         fin_ff       <= fin_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      win_ff  <= win_in;
      vars_ff <= vars_in;
      len_ff  <= len_in;
   end

endmodule

[verif/sha256_digest_checker.sv]
module sha256_digest_checker
   import shs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              mismatch_count,
   output int              words_pending
);

   localparam logic [7:0] PAD_START = 8'h80;
   localparam int unsigned LENGTH_FIELD_POS = 56;
   localparam int unsigned BLOCK_BYTES = 64;

   localparam logic [31:0] SEED_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [31:0]     chain [8];
   logic [7:0]      block_bytes [64];
   logic [63:0]     message_bits;
   int unsigned     block_fill;
   rsp_payload_type digest_queue [$];

   function automatic logic [31:0] rot_right(input logic [31:0] x, input int unsigned n);
      logic [63:0] doubled;
      doubled = {x, x} >> n;
      return doubled[31:0];
   endfunction

   function automatic void restart_hash();
      chain = SEED_HASH;
      message_bits = '0;
      block_fill = 0;
   endfunction

   function automatic void compress_block();
      logic [31:0] sched [64];
      logic [31:0] v [8];
      logic [31:0] sig0, sig1, choose, major, tmp1, tmp2;
      int unsigned t;
      for (t = 0; t < 16; t++)
         sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                     block_bytes[4*t+3]};
      for (t = 16; t < 64; t++) begin
         sig0 = rot_right(sched[t-15], 7) ^ rot_right(sched[t-15], 18) ^ (sched[t-15] >> 3);
         sig1 = rot_right(sched[t-2], 17) ^ rot_right(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = sched[t-16] + sig0 + sched[t-7] + sig1;
      end
      v = chain;
      for (t = 0; t < 64; t++) begin
         sig1 = rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25);
         choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
         tmp1 = v[7] + sig1 + choose + ROUND_CONST[t] + sched[t];
         sig0 = rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22);
         major = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         tmp2 = sig0 + major;
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + tmp1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = tmp1 + tmp2;
      end
      for (t = 0; t < 8; t++)
         chain[t] = chain[t] + v[t];
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      block_bytes[block_fill] = b;
      block_fill++;
      if (block_fill == BLOCK_BYTES) begin
         compress_block();
         block_fill = 0;
      end
   endfunction

   function automatic void absorb_transaction(input req_payload_type item);
      logic [63:0]     length_bits;
      rsp_payload_type word;
      int unsigned     i;
      if (item.has_byte) begin
         message_bits = message_bits + 64'd8;
         append_byte(item.data_byte);
      end
      if (!item.end_of_message)
         return;
      length_bits = message_bits;
      append_byte(PAD_START);
      if (block_fill > LENGTH_FIELD_POS)
         while (block_fill != 0)
            append_byte(8'h00);
      while (block_fill < LENGTH_FIELD_POS)
         append_byte(8'h00);
      for (i = 0; i < 8; i++)
         append_byte(length_bits[63 - 8*i -: 8]);
      for (i = 0; i < 8; i++) begin
         word.digest_word = chain[i];
         word.word_index = 3'(i);
         word.last_word = (i == 7);
         digest_queue.push_back(word);
      end
      restart_hash();
   endfunction

   function automatic void check_digest_word(input rsp_payload_type got);
      rsp_payload_type want;
      if (digest_queue.size() == 0) begin
         $error("unexpected digest word %h, word_index %0d", got.digest_word, got.word_index);
         mismatch_count++;
         return;
      end
      want = digest_queue.pop_front();
      if (got.digest_word !== want.digest_word) begin
         $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
         mismatch_count++;
      end
      if (got.word_index !== want.word_index) begin
         $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
         mismatch_count++;
      end
      if (got.last_word !== want.last_word) begin
         $error("last_word: expected %0b, actual %0b", want.last_word, got.last_word);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart_hash();
         digest_queue.delete();
      end else begin
         if (req_valid && req_ready)
            absorb_transaction(req_payload);
         if (rsp_valid && rsp_ready)
            check_digest_word(rsp_payload);
      end
      words_pending <= digest_queue.size();
   end

endmodule

[verif/sha256_stream_hasher_top_tb.sv]
module sha256_stream_hasher_top_tb
   import shs_pkg::*;
();

   localparam int IDLE_PERCENT    = 24;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int RANDOM_ITEMS    = 300;

   logic clock;
   logic reset;

   shs_stream_if #(.payload_type(req_payload_type)) req_if ();
   shs_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   int mismatch_count;
   int words_pending;
   int items_sent;
   int stalled_cycles;
   bit idle_on;
   bit hold_request;
   bit hold_served;

   sha256_stream_hasher_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   sha256_digest_checker digest_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_payload    (req_if.payload),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_payload    (rsp_if.payload),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      rsp_if.ready <= 1'b0;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else begin
            rsp_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic offer(input logic [7:0] data, input logic has, input logic eom);
      req_payload_type item;
      item.data_byte = data;
      item.has_byte = has;
      item.end_of_message = eom;
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      if (has || eom)
         items_sent++;
   endtask

   task automatic send_message(input int unsigned len, input bit end_alone);
      int unsigned i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(99) < 5)
            offer(8'($urandom), 1'b0, 1'b0);
         offer(8'($urandom), 1'b1, !end_alone && (i == len - 1));
      end
      if (end_alone || len == 0)
         offer(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_for_digests();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   // favor lengths around the padding spill points
   function automatic int unsigned pick_length();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom_range(12, 0);
         4, 5, 6:    return $urandom_range(58, 54);
         7:          return $urandom_range(66, 62);
         8:          return $urandom_range(121, 118);
         default:    return $urandom_range(53, 13);
      endcase
   endfunction

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      idle_on <= 1'b1;
      hold_request <= 1'b0;
      items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      offer(8'hff, 1'b0, 1'b1);
      offer(8'h5a, 1'b0, 1'b0);
      offer(8'h00, 1'b1, 1'b1);
      offer(8'hff, 1'b1, 1'b1);
      offer(8'h80, 1'b1, 1'b0);
      offer(8'hff, 1'b0, 1'b0);
      offer(8'h00, 1'b0, 1'b1);
      offer(8'h61, 1'b1, 1'b0);
      offer(8'h62, 1'b1, 1'b0);
      offer(8'h63, 1'b1, 1'b1);
      wait_for_digests();

      idle_on <= 1'b0;
      while (items_sent < 90)
         send_message(pick_length(), 1'($urandom_range(1)));
      wait_for_digests();
      idle_on <= 1'b1;

      // hold the receiver so the block backs up and stalls its input
      hold_request <= 1'b1;
      send_message(3, 1'b0);
      send_message(20, 1'b1);
      send_message(5, 1'b0);
      wait_for_digests();

      while (items_sent < RANDOM_ITEMS)
         send_message(pick_length(), 1'($urandom_range(1)));
      wait_for_digests();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && words_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[sha256_stream_hasher_top.f]
design/shs_pkg.sv
design/shs_stream_if.sv
design/shs_round.sv
design/sha256_stream_hasher_top.sv
verif/sha256_digest_checker.sv
verif/sha256_stream_hasher_top_tb.sv
